// File: rtl/fchc_pkg.sv
// shared types and constants of the fan curve controller
`default_nettype none
package fchc_pkg;

  localparam int TempInW   = 9;
  localparam int DegW      = 7;
  localparam int SpeedW    = 7;
  localparam int SifW      = 8;
  localparam int HystW     = 6;
  localparam int PcountW   = 4;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 56;
  localparam int PointW    = DegW + SpeedW;
  localparam int PointsPerReg = 4;

  localparam logic [DegW-1:0]   TempMax      = 7'd120;
  localparam logic [SpeedW-1:0] SpeedDefault = 7'd100;
  localparam logic signed [SifW-1:0] SpeedAuto = -8'sd1;
  localparam logic [DegW-1:0]   WarnReset    = 7'd80;

  typedef enum logic [CfgIdxW-1:0] {
    REG_HYSTERESIS = 3'd0,
    REG_WARN_LEVEL = 3'd1,
    REG_POINT_CNT  = 3'd2,
    REG_CURVE_A    = 3'd3,
    REG_CURVE_B    = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } ctrl_state_e;

  typedef struct packed {
    logic [SpeedW-1:0] speed;
    logic [DegW-1:0]   temp;
  } point_t;

  typedef struct packed {
    logic signed [TempInW-1:0] temperature;
    logic                      manual_ack;
    logic                      speed_ack;
    logic                      auto_ack;
  } in_beat_t;

  typedef struct packed {
    logic [SpeedW-1:0]      speed_target;
    logic signed [SifW-1:0] current_speed;
    logic                   auto_active;
    logic                   read_error;
    logic                   temp_warning;
    logic                   speed_set;
    logic                   speed_set_error;
    logic                   manual_set_error;
    logic                   auto_set;
    logic                   auto_set_error;
    logic                   change_requested;
  } out_beat_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic rescan;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic bad_temp;
    logic scan_done;
    logic rescan_needed;
    logic out_busy;
  } dp_status_t;

endpackage
`default_nettype wire

// File: rtl/fchc_stream_if.sv
// valid/ready stream channel carrying one beat of payload
`default_nettype none
interface fchc_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/fan_curve_hysteresis_controller_top.sv
// an out-of-range sample skips the curve scan and goes to commit; otherwise
// one curve point is compared per cycle, and a second pass with the hysteresis offset
// runs when the speed would drop; the commit waits while the output is stalled; the
// next sample is taken the cycle after the result is registered, which may be while
// that result still waits on the output
// reset: config to defaults (warn level 80), speed in force -1, automatic mode off
`default_nettype none
module fan_curve_hysteresis_controller_top #(
  parameter int MAX_POINTS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  fchc_stream_if.sink                   in_i,
  fchc_stream_if.source                 out_o,
  input  logic                          cfg_we_i,
  input  logic [fchc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [fchc_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import fchc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  fchc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  fchc_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_i.data),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_data_o  (out_o.data)
  );

endmodule
`default_nettype wire

// File: rtl/fchc_ctrl.sv
// sequencer: accept, one or two curve scans (none for an out-of-range sample), commit of the result
`default_nettype none
module fchc_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output fchc_pkg::ctrl_cmd_t    cmd_o,
  input  fchc_pkg::dp_status_t   status_i
);
  import fchc_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status_i.bad_temp) begin
          state_d = ST_COMMIT;
        end else begin
          cmd_o.scan = 1'b1;
          if (status_i.scan_done) begin
            // lowering the speed: scan again with the hysteresis offset
            if (status_i.rescan_needed) begin
              cmd_o.rescan = 1'b1;
            end else begin
              state_d = ST_COMMIT;
            end
          end
        end
      end
      ST_COMMIT: begin
        if (!status_i.out_busy) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/fchc_dp.sv
// datapath: config registers, curve point scan, fan state and result register
`default_nettype none
module fchc_dp #(
  parameter int MAX_POINTS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  fchc_pkg::ctrl_cmd_t               cmd_i,
  output fchc_pkg::dp_status_t              status_o,
  input  fchc_pkg::in_beat_t                in_data_i,
  input  logic                              cfg_we_i,
  input  logic [fchc_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [fchc_pkg::CfgDataW-1:0]     cfg_wdata_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output fchc_pkg::out_beat_t               out_data_o
);
  import fchc_pkg::*;

  localparam int IdxW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CntW = $clog2(MAX_POINTS + 1);

  // configuration
  logic [HystW-1:0]   hyst_q;
  logic [DegW-1:0]    warn_q;
  logic [PcountW-1:0] pcount_q;
  point_t             pts_q [MAX_POINTS];

  // per-sample working registers
  in_beat_t           sample_q;
  logic [CntW-1:0]    cnt_q;
  logic               pass2_q;
  logic [SpeedW-1:0]  target_q;

  // fan state
  logic signed [SifW-1:0] sif_q, sif_d;
  logic                   auto_q, auto_d;

  logic      out_valid_q;
  out_beat_t out_q, beat_d;

  logic              bad;
  logic [DegW-1:0]   temp7;
  logic [CntW-1:0]   n_eff;
  logic              in_range;
  point_t            pt;
  logic [DegW:0]     lhs;
  logic              hit;
  logic              done;
  logic [SpeedW-1:0] res;
  logic              lower;
  logic              auto_cur;
  logic              fall;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hyst_q   <= '0;
      warn_q   <= WarnReset;
      pcount_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_HYSTERESIS: hyst_q   <= cfg_wdata_i[HystW-1:0];
        REG_WARN_LEVEL: warn_q   <= cfg_wdata_i[DegW-1:0];
        REG_POINT_CNT:  pcount_q <= cfg_wdata_i[PcountW-1:0];
        default: ;
      endcase
    end
  end

  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_pt
    localparam int       Lo     = (k % PointsPerReg) * PointW;
    localparam cfg_reg_e SrcReg = (k < PointsPerReg) ? REG_CURVE_A : REG_CURVE_B;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pts_q[k] <= '0;
      end else if (cfg_we_i && cfg_idx_i == SrcReg) begin
        pts_q[k] <= point_t'(cfg_wdata_i[Lo +: PointW]);
      end
    end
  end

  // one curve point per cycle
  assign bad      = sample_q.temperature[TempInW-1] ||
                    (sample_q.temperature[SifW-1:0] > {1'b0, TempMax});
  assign temp7    = sample_q.temperature[DegW-1:0];
  assign n_eff    = (pcount_q > PcountW'(MAX_POINTS)) ? CntW'(MAX_POINTS)
                                                      : CntW'(pcount_q);
  assign in_range = cnt_q < n_eff;
  assign pt       = pts_q[cnt_q[IdxW-1:0]];
  // temp < point - offset, kept unsigned as temp + offset < point
  assign lhs      = {1'b0, temp7} + (pass2_q ? {2'b00, hyst_q} : '0);
  assign hit      = in_range && (lhs < {1'b0, pt.temp});
  assign done     = !in_range || hit;
  assign res      = hit ? pt.speed : SpeedDefault;
  assign lower    = $signed({1'b0, res}) < sif_q;

  assign status_o.bad_temp      = bad;
  assign status_o.scan_done     = done;
  assign status_o.rescan_needed = !pass2_q && lower;
  assign status_o.out_busy      = out_valid_q && !out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sample_q <= in_data_i;
    end
    if (cmd_i.scan && done) begin
      target_q <= res;
    end
    if (cmd_i.commit) begin
      out_q <= beat_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      pass2_q <= 1'b0;
    end else if (cmd_i.load || cmd_i.rescan) begin
      cnt_q   <= '0;
      pass2_q <= cmd_i.rescan;
    end else if (cmd_i.scan && !done) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // outcome of the device requests for this sample
  always_comb begin
    beat_d   = '0;
    sif_d    = sif_q;
    auto_cur = auto_q;
    fall     = 1'b0;
    if (bad) begin
      beat_d.read_error = 1'b1;
      fall              = 1'b1;
    end else begin
      beat_d.temp_warning = temp7 >= warn_q;
      beat_d.speed_target = target_q;
      if ({1'b0, target_q} != sif_q) begin
        beat_d.change_requested = 1'b1;
        if (sample_q.manual_ack) begin
          auto_cur = 1'b0;
        end else begin
          beat_d.manual_set_error = 1'b1;
        end
        if (sample_q.speed_ack) begin
          sif_d            = $signed({1'b0, target_q});
          beat_d.speed_set = 1'b1;
        end else begin
          beat_d.speed_set_error = 1'b1;
          fall                   = 1'b1;
        end
      end
    end
    auto_d = auto_cur;
    if (fall) begin
      if (auto_cur || sample_q.auto_ack) begin
        sif_d           = SpeedAuto;
        auto_d          = 1'b1;
        beat_d.auto_set = 1'b1;
      end else begin
        beat_d.auto_set_error = 1'b1;
      end
    end
    beat_d.current_speed = sif_d;
    beat_d.auto_active   = auto_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sif_q       <= SpeedAuto;
      auto_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        sif_q       <= sif_d;
        auto_q      <= auto_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// File: rtl/fchc_checker.sv
// port-level checks on the result channel, bound to the top level
`default_nettype none
module fchc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input fchc_pkg::out_beat_t out_data_i
);
  import fchc_pkg::*;

  // a waiting beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result beat changed while stalled");

  // a bad sample makes no speed request and gives no target
  a_read_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.read_error |->
      !out_data_i.change_requested && !out_data_i.temp_warning &&
      out_data_i.speed_target == '0)
    else $error("read error beat carries a speed request");

  // a speed write is either accepted or rejected, never both
  a_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.change_requested |->
      out_data_i.speed_set != out_data_i.speed_set_error)
    else $error("speed write outcome inconsistent");

  a_speed_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.speed_set |->
      out_data_i.current_speed == $signed({1'b0, out_data_i.speed_target}))
    else $error("accepted speed not in force");

  a_auto_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.auto_set |->
      out_data_i.auto_active && out_data_i.current_speed == SpeedAuto)
    else $error("fallback to automatic not reflected");

endmodule

bind fan_curve_hysteresis_controller_top fchc_checker u_fchc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
`default_nettype wire
